[rtl/ttlq_pkg.sv]
// Shared types and constants for the TTL aging eviction queue.
// Used by ttlq_cfg, ttlq_ctrl, ttlq_dpath and the top level; no dependencies.
`timescale 1ns / 1ps

package ttlq_pkg;

    // Sizes of the queue and of the entry flag tables
    localparam int QUEUE_DEPTH = 64;
    localparam int ENTRY_COUNT = 64;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W       = $clog2(ENTRY_COUNT);

    // Field widths
    localparam int OP_W   = 3;
    localparam int ID_W   = 6;
    localparam int KIND_W = 2;
    localparam int EXP_W  = 32;
    localparam int CFG_W  = 16;
    localparam int POP_W  = 2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] INIT_MIN_FRAMES   = 16'd50;
    localparam logic [CFG_W-1:0] INIT_MAX_FRAMES   = 16'd600;
    localparam logic [CFG_W-1:0] INIT_USAGE_GROWTH = 16'd10;

    // Tick walk divisors
    localparam int NORMAL_DIV   = 20;
    localparam int RESIDENT_DIV = 300;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_KEEP_RESIDENT = 2'd0,
        REG_MIN_FRAMES    = 2'd1,
        REG_MAX_FRAMES    = 2'd2,
        REG_USAGE_GROWTH  = 2'd3
    } t_reg;

    // Operation codes; the two spare codes act as no-ops
    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 3'd0,
        OP_USED    = 3'd1,
        OP_SET_ACT = 3'd2,
        OP_CLR_ACT = 3'd3,
        OP_DESTROY = 3'd4,
        OP_TICK    = 3'd5
    } t_op;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DONE   = 2'd0,
        KIND_UNLOAD = 2'd1,
        KIND_FULL   = 2'd2
    } t_kind;

    // Configuration register contents
    typedef struct packed {
        logic             keep_resident;
        logic [CFG_W-1:0] min_frames;
        logic [CFG_W-1:0] max_frames;
        logic [CFG_W-1:0] usage_growth;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;
        logic disp;
        logic evt;
        logic rd;
        logic eval;
        logic wb;
        logic fin;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_tick;
        logic q_empty;
        logic pops_zero;
        logic wb_emit;
        logic out_free;
    } t_sts;

endpackage

[rtl/ttlq_cfg.sv]
// APB-style configuration registers of the TTL aging eviction queue.
// Depends on ttlq_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps

module ttlq_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ttlq_pkg::t_cfg      o_cfg
);

    ttlq_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Write a register at the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_resident <= 1'b0;
            r_cfg.min_frames    <= ttlq_pkg::INIT_MIN_FRAMES;
            r_cfg.max_frames    <= ttlq_pkg::INIT_MAX_FRAMES;
            r_cfg.usage_growth  <= ttlq_pkg::INIT_USAGE_GROWTH;
        end else if (wr_en) begin
            unique case (reg_idx)
                ttlq_pkg::REG_KEEP_RESIDENT: r_cfg.keep_resident <= pwdata[0];
                ttlq_pkg::REG_MIN_FRAMES:    r_cfg.min_frames    <= pwdata[15:0];
                ttlq_pkg::REG_MAX_FRAMES:    r_cfg.max_frames    <= pwdata[15:0];
                ttlq_pkg::REG_USAGE_GROWTH:  r_cfg.usage_growth  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            ttlq_pkg::REG_KEEP_RESIDENT: prdata = {31'd0, r_cfg.keep_resident};
            ttlq_pkg::REG_MIN_FRAMES:    prdata = {16'd0, r_cfg.min_frames};
            ttlq_pkg::REG_MAX_FRAMES:    prdata = {16'd0, r_cfg.max_frames};
            ttlq_pkg::REG_USAGE_GROWTH:  prdata = {16'd0, r_cfg.usage_growth};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

[rtl/ttlq_ctrl.sv]
// Sequencing state machine of the TTL aging eviction queue.
// Depends on ttlq_pkg for the command and status structs.
`timescale 1ns / 1ps

module ttlq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ttlq_pkg::t_sts  i_sts,
    output logic            o_in_stall,
    output ttlq_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DISP = 7'b0000010,
        ST_EVT  = 7'b0000100,
        ST_RD   = 7'b0001000,
        ST_EVAL = 7'b0010000,
        ST_WB   = 7'b0100000,
        ST_FIN  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   wb_go;

    assign o_in_stall = (r_state != ST_IDLE);
    // A writeback that unloads needs a free output slot
    assign wb_go      = !i_sts.wb_emit || i_sts.out_free;

    // Decode commands from the state
    always_comb begin
        o_cmd       = '0;
        o_cmd.latch = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.disp  = (r_state == ST_DISP);
        o_cmd.evt   = (r_state == ST_EVT);
        o_cmd.rd    = (r_state == ST_RD);
        o_cmd.eval  = (r_state == ST_EVAL);
        o_cmd.wb    = (r_state == ST_WB) && wb_go;
        o_cmd.fin   = (r_state == ST_FIN) && i_sts.out_free;
    end

    // Advance through event or tick sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DISP;
            end
            ST_DISP: begin
                if (!i_sts.is_tick)     n_state = ST_EVT;
                else if (i_sts.q_empty) n_state = ST_FIN;
                else                    n_state = ST_RD;
            end
            ST_EVT:  n_state = ST_FIN;
            ST_RD:   n_state = ST_EVAL;
            ST_EVAL: n_state = ST_WB;
            ST_WB: begin
                if (wb_go) n_state = i_sts.pops_zero ? ST_FIN : ST_RD;
            end
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/ttlq_dpath.sv]
// Datapath of the TTL aging eviction queue: queue memory, pointers, entry
// flags, frame counter, expiry arithmetic and the result register.
// Depends on ttlq_pkg for sizes, codes and the command/status structs.
`timescale 1ns / 1ps

module ttlq_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttlq_pkg::t_cmd                i_cmd,
    input  ttlq_pkg::t_cfg                i_cfg,
    input  logic [ttlq_pkg::OP_W-1:0]     i_operation,
    input  logic [ttlq_pkg::ID_W-1:0]     i_entry_id,
    input  logic                          i_out_stall,
    output ttlq_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    output logic [ttlq_pkg::KIND_W-1:0]   o_kind,
    output logic [ttlq_pkg::ID_W-1:0]     o_entry_id_res,
    output logic                          o_last
);

    localparam int QA_W  = ttlq_pkg::QA_W;
    localparam int CNT_W = ttlq_pkg::CNT_W;
    localparam int ENT_W = ttlq_pkg::ENT_W;
    localparam int ID_W  = ttlq_pkg::ID_W;
    localparam int EXP_W = ttlq_pkg::EXP_W;
    localparam int POP_W = ttlq_pkg::POP_W;
    localparam int MEM_W = ID_W + EXP_W;
    localparam int NE    = ttlq_pkg::ENTRY_COUNT;
    localparam int QD    = ttlq_pkg::QUEUE_DEPTH;

    typedef enum logic [1:0] {
        FATE_DROP  = 2'd0,
        FATE_ACT   = 2'd1,
        FATE_USED  = 2'd2,
        FATE_PLAIN = 2'd3
    } t_fate;

    // Latched input word and its pending result
    logic [ttlq_pkg::OP_W-1:0]   r_op;
    logic [ID_W-1:0]             r_id;
    logic [ttlq_pkg::KIND_W-1:0] r_res_kind;
    logic [ID_W-1:0]             r_res_id;

    // Queue state
    logic [MEM_W-1:0] r_mem [QD];
    logic [MEM_W-1:0] r_rd_data;
    logic [QA_W-1:0]  r_head;
    logic [CNT_W-1:0] r_count;
    logic [POP_W-1:0] r_pops;
    logic [EXP_W-1:0] r_frame;
    logic [NE-1:0]    r_alive;
    logic [NE-1:0]    r_active;
    logic [NE-1:0]    r_used;

    // Evaluation results of the popped entry
    t_fate            r_fate;
    logic [EXP_W-1:0] r_sum;
    logic [EXP_W-1:0] r_cap;
    logic             r_expired;

    // Output register
    logic                        r_out_valid;
    logic [ttlq_pkg::KIND_W-1:0] r_out_kind;
    logic [ID_W-1:0]             r_out_id;
    logic                        r_out_last;

    logic                 is_tick;
    logic                 cmd_ok;
    logic [ENT_W-1:0]     cmd_idx;
    logic                 q_full;
    logic [QA_W:0]        tail_sum;
    logic [QA_W-1:0]      tail;
    logic [QA_W-1:0]      head_inc;
    logic [ID_W-1:0]      rd_id;
    logic [EXP_W-1:0]     rd_exp;
    logic [ENT_W-1:0]     rd_idx;
    logic                 rd_live;
    logic [EXP_W-1:0]     min_ext;
    logic [EXP_W-1:0]     max_ext;
    logic [EXP_W-1:0]     grow_ext;
    logic [EXP_W-1:0]     frame_min;
    logic [EXP_W-1:0]     new_exp;
    logic                 wb_emit;
    logic                 evt_push;
    logic                 wb_push;
    logic                 push;
    logic [MEM_W-1:0]     wr_data;
    logic [POP_W-1:0]     pop_n;
    logic [31:0]          div;
    logic                 out_free;

    assign is_tick  = (r_op == ttlq_pkg::OP_TICK);
    assign cmd_ok   = (32'(r_id) < 32'(NE));
    assign cmd_idx  = ENT_W'(r_id);
    assign q_full   = (r_count >= CNT_W'(QD));
    assign min_ext  = EXP_W'(i_cfg.min_frames);
    assign max_ext  = EXP_W'(i_cfg.max_frames);
    assign grow_ext = EXP_W'(i_cfg.usage_growth);
    assign frame_min = r_frame + min_ext;

    // Tail slot and head advance, wrapped at the queue depth
    assign tail_sum = (QA_W + 1)'(r_head) + (QA_W + 1)'(r_count);
    assign tail     = (tail_sum >= (QA_W + 1)'(QD)) ? QA_W'(tail_sum - (QA_W + 1)'(QD))
                                                     : QA_W'(tail_sum);
    assign head_inc = (r_head == QA_W'(QD - 1)) ? '0 : r_head + 1'b1;

    // Pop count: max(count/div, 1), limited to three and to the entries present
    assign div = i_cfg.keep_resident ? 32'(ttlq_pkg::RESIDENT_DIV)
                                     : 32'(ttlq_pkg::NORMAL_DIV);
    always_comb begin
        if (32'(r_count) >= 3 * div)      pop_n = 2'd3;
        else if (32'(r_count) >= 2 * div) pop_n = 2'd2;
        else                              pop_n = 2'd1;
        if (32'(r_count) < 32'(pop_n)) pop_n = POP_W'(r_count);
    end

    // Popped entry fields
    assign rd_id   = r_rd_data[MEM_W-1:EXP_W];
    assign rd_exp  = r_rd_data[EXP_W-1:0];
    assign rd_idx  = ENT_W'(rd_id);
    assign rd_live = (32'(rd_id) < 32'(NE)) && r_alive[rd_idx];

    // Pick the refreshed expiry
    always_comb begin
        case (r_fate)
            FATE_ACT:  new_exp = (rd_exp < r_sum) ? r_sum : rd_exp;
            FATE_USED: new_exp = (r_sum < r_cap) ? r_sum : r_cap;
            default:   new_exp = rd_exp;
        endcase
    end

    assign wb_emit  = !i_cfg.keep_resident && (r_fate == FATE_PLAIN) && r_expired;
    assign evt_push = i_cmd.evt && (r_op == ttlq_pkg::OP_LOAD) && cmd_ok && !q_full;
    assign wb_push  = i_cmd.wb && (r_fate != FATE_DROP) && !wb_emit;
    assign push     = evt_push || wb_push;
    assign wr_data  = i_cmd.evt ? {r_id, frame_min} : {rd_id, new_exp};
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.is_tick   = is_tick;
    assign o_sts.q_empty   = (r_count == '0);
    assign o_sts.pops_zero = (r_pops == '0);
    assign o_sts.wb_emit   = wb_emit;
    assign o_sts.out_free  = out_free;

    // Latch the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_operation;
            r_id <= i_entry_id;
        end
    end

    // Track the result of an event
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_res_kind <= ttlq_pkg::KIND_DONE;
            r_res_id   <= '0;
        end else if (i_cmd.evt && (r_op == ttlq_pkg::OP_LOAD) && cmd_ok && q_full) begin
            r_res_kind <= ttlq_pkg::KIND_FULL;
            r_res_id   <= r_id;
        end
    end

    // Queue memory: write at the tail, read the head
    always_ff @(posedge i_clk) begin
        if (push) r_mem[tail] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd_data <= r_mem[r_head];
    end

    // Head, count, pops left and frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_pops  <= '0;
            r_frame <= '0;
        end else begin
            if (i_cmd.disp && is_tick) r_pops <= pop_n;
            if (i_cmd.rd) begin
                r_head  <= head_inc;
                r_count <= r_count - 1'b1;
                r_pops  <= r_pops - 1'b1;
            end else if (push) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.fin && is_tick && !i_cfg.keep_resident) r_frame <= r_frame + 1'b1;
        end
    end

    // Entry flags: set and cleared by events, used cleared when a tick refreshes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive  <= '0;
            r_active <= '0;
            r_used   <= '0;
        end else if (i_cmd.evt && cmd_ok) begin
            case (r_op)
                ttlq_pkg::OP_LOAD:    r_alive[cmd_idx]  <= 1'b1;
                ttlq_pkg::OP_USED:    r_used[cmd_idx]   <= 1'b1;
                ttlq_pkg::OP_SET_ACT: r_active[cmd_idx] <= 1'b1;
                ttlq_pkg::OP_CLR_ACT: r_active[cmd_idx] <= 1'b0;
                ttlq_pkg::OP_DESTROY: begin
                    r_alive[cmd_idx]  <= 1'b0;
                    r_active[cmd_idx] <= 1'b0;
                    r_used[cmd_idx]   <= 1'b0;
                end
                default: ;
            endcase
        end else if (i_cmd.eval && !i_cfg.keep_resident && rd_live
                     && !r_active[rd_idx] && r_used[rd_idx]) begin
            r_used[rd_idx] <= 1'b0;
        end
    end

    // Classify the popped entry and form its candidate expiries
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_expired <= (rd_exp < r_frame);
            r_cap     <= r_frame + max_ext;
            if (!rd_live) begin
                r_fate <= FATE_DROP;
                r_sum  <= rd_exp;
            end else if (i_cfg.keep_resident) begin
                r_fate <= FATE_PLAIN;
                r_sum  <= rd_exp;
            end else if (r_active[rd_idx]) begin
                r_fate <= FATE_ACT;
                r_sum  <= frame_min;
            end else if (r_used[rd_idx]) begin
                r_fate <= FATE_USED;
                r_sum  <= rd_exp + grow_ext;
            end else begin
                r_fate <= FATE_PLAIN;
                r_sum  <= rd_exp;
            end
        end
    end

    // Output register: load an unload or a final word, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin || (i_cmd.wb && wb_emit)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_kind <= r_res_kind;
            r_out_id   <= r_res_id;
            r_out_last <= 1'b1;
        end else if (i_cmd.wb && wb_emit) begin
            r_out_kind <= ttlq_pkg::KIND_UNLOAD;
            r_out_id   <= rd_id;
            r_out_last <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_entry_id_res = r_out_id;
    assign o_last         = r_out_last;

endmodule

[rtl/ttl_aging_eviction_queue.sv]
// Top level of the TTL aging eviction queue.
// Instantiates ttlq_cfg, ttlq_ctrl and ttlq_dpath; types from ttlq_pkg.
//
//   channel   handshake                 payload
//   input     i_in_valid / o_in_stall   i_operation, i_entry_id
//   result    o_out_valid / i_out_stall o_kind, o_entry_id_res, o_last
//   config    psel penable pwrite pready paddr, pwdata, prdata
//
// An event steps through dispatch, event and final states; its result word is loaded in
// the final state. A tick goes through dispatch, a memory read, evaluate and writeback
// per popped entry (at most 3) and the final state, where its final word is loaded.
// Each writeback requeues, unloads or drops the entry. Words are taken only when idle.
// Reset is synchronous and clears pointers, flags and the frame counter.
// A stalled result holds the sequencer only when a new word must be loaded.
`timescale 1ns / 1ps

module ttl_aging_eviction_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ttlq_pkg::OP_W-1:0]     i_operation,
    input  logic [ttlq_pkg::ID_W-1:0]     i_entry_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ttlq_pkg::KIND_W-1:0]   o_kind,
    output logic [ttlq_pkg::ID_W-1:0]     o_entry_id_res,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    ttlq_pkg::t_cfg cfg;
    ttlq_pkg::t_cmd cmd;
    ttlq_pkg::t_sts sts;

    ttlq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ttlq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ttlq_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_operation    (i_operation),
        .i_entry_id     (i_entry_id),
        .i_out_stall    (i_out_stall),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_entry_id_res (o_entry_id_res),
        .o_last         (o_last)
    );

endmodule

[tb/ttlq_checker.sv]
// Checker for the TTL aging eviction queue: watches both word channels and the
// register port, predicts every result word and compares it. Types from ttlq_pkg.
`timescale 1ns / 1ps

module ttlq_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [ttlq_pkg::OP_W-1:0]   i_operation,
    input  logic [ttlq_pkg::ID_W-1:0]   i_entry_id,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [ttlq_pkg::KIND_W-1:0] i_kind,
    input  logic [ttlq_pkg::ID_W-1:0]   i_entry_id_res,
    input  logic                        i_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output int                          o_fail_count,
    output int                          o_words_owed
);

    localparam int ID_W        = ttlq_pkg::ID_W;
    localparam int OP_W        = ttlq_pkg::OP_W;
    localparam int EXP_W       = ttlq_pkg::EXP_W;
    localparam int CFG_W       = ttlq_pkg::CFG_W;
    localparam int QUEUE_DEPTH = ttlq_pkg::QUEUE_DEPTH;
    localparam int ENTRY_COUNT = ttlq_pkg::ENTRY_COUNT;
    localparam int MAX_POPS    = 3;

    typedef struct packed {
        ttlq_pkg::t_kind kind;
        logic [ID_W-1:0] id;
        logic            last;
    } t_result_word;

    // Predicted queue contents and entry flags
    logic [ID_W-1:0]        slot_id  [QUEUE_DEPTH];
    logic [EXP_W-1:0]       slot_exp [QUEUE_DEPTH];
    int                     head;
    int                     count;
    logic [EXP_W-1:0]       frame;
    logic [ENTRY_COUNT-1:0] alive;
    logic [ENTRY_COUNT-1:0] active;
    logic [ENTRY_COUNT-1:0] used;

    // Shadow of the configuration registers
    logic                   keep_resident;
    logic [CFG_W-1:0]       min_frames;
    logic [CFG_W-1:0]       max_frames;
    logic [CFG_W-1:0]       usage_growth;

    t_result_word           owed_words[$];
    int                     fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic void clear_state();
        head          = 0;
        count         = 0;
        frame         = '0;
        alive         = '0;
        active        = '0;
        used          = '0;
        keep_resident = 1'b0;
        min_frames    = ttlq_pkg::INIT_MIN_FRAMES;
        max_frames    = ttlq_pkg::INIT_MAX_FRAMES;
        usage_growth  = ttlq_pkg::INIT_USAGE_GROWTH;
        owed_words.delete();
    endfunction

    function automatic void owe(ttlq_pkg::t_kind kind, logic [ID_W-1:0] id, logic last);
        t_result_word w;
        w.kind = kind;
        w.id   = id;
        w.last = last;
        owed_words.push_back(w);
    endfunction

    function automatic void enqueue(logic [ID_W-1:0] id, logic [EXP_W-1:0] expiry);
        int tail;
        tail           = (head + count) % QUEUE_DEPTH;
        slot_id[tail]  = id;
        slot_exp[tail] = expiry;
        count++;
    endfunction

    // Walk the head of the queue: drop dead, refresh active and used, unload expired
    function automatic void age_tick();
        int               n;
        logic [ID_W-1:0]  id;
        logic [EXP_W-1:0] e;
        logic [EXP_W-1:0] floor_e;
        logic [EXP_W-1:0] grown;
        logic [EXP_W-1:0] cap;
        n = keep_resident ? count / ttlq_pkg::RESIDENT_DIV : count / ttlq_pkg::NORMAL_DIV;
        if (n < 1) n = 1;
        if (n > MAX_POPS) n = MAX_POPS;
        if (n > count) n = count;
        repeat (n) begin
            id    = slot_id[head];
            e     = slot_exp[head];
            head  = (head + 1) % QUEUE_DEPTH;
            count--;
            if (!alive[id]) begin
                // dead entry leaves the queue silently
            end else if (keep_resident) begin
                enqueue(id, e);
            end else if (active[id]) begin
                floor_e = frame + EXP_W'(min_frames);
                enqueue(id, (e < floor_e) ? floor_e : e);
            end else if (used[id]) begin
                used[id] = 1'b0;
                grown    = e + EXP_W'(usage_growth);
                cap      = frame + EXP_W'(max_frames);
                enqueue(id, (grown < cap) ? grown : cap);
            end else if (e < frame) begin
                owe(ttlq_pkg::KIND_UNLOAD, id, 1'b0);
            end else begin
                enqueue(id, e);
            end
        end
        if (!keep_resident) frame++;
        owe(ttlq_pkg::KIND_DONE, '0, 1'b1);
    endfunction

    // Apply one accepted input word to the predicted state
    function automatic void take_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
        if (op == ttlq_pkg::OP_TICK) begin
            age_tick();
            return;
        end
        case (op)
            ttlq_pkg::OP_LOAD: begin
                alive[id] = 1'b1;
                if (count >= QUEUE_DEPTH) begin
                    owe(ttlq_pkg::KIND_FULL, id, 1'b1);
                    return;
                end
                enqueue(id, frame + EXP_W'(min_frames));
            end
            ttlq_pkg::OP_USED:    used[id]   = 1'b1;
            ttlq_pkg::OP_SET_ACT: active[id] = 1'b1;
            ttlq_pkg::OP_CLR_ACT: active[id] = 1'b0;
            ttlq_pkg::OP_DESTROY: begin
                alive[id]  = 1'b0;
                active[id] = 1'b0;
                used[id]   = 1'b0;
            end
            default: ;
        endcase
        owe(ttlq_pkg::KIND_DONE, '0, 1'b1);
    endfunction

    function automatic void write_cfg(logic [3:0] addr, logic [31:0] data);
        case (ttlq_pkg::t_reg'(addr[3:2]))
            ttlq_pkg::REG_KEEP_RESIDENT: keep_resident = data[0];
            ttlq_pkg::REG_MIN_FRAMES:    min_frames    = data[CFG_W-1:0];
            ttlq_pkg::REG_MAX_FRAMES:    max_frames    = data[CFG_W-1:0];
            ttlq_pkg::REG_USAGE_GROWTH:  usage_growth  = data[CFG_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("ttlq_checker @%0t: %s", $realtime, what);
    endtask

    // Compare one accepted result word with the oldest owed word
    task automatic check_word();
        t_result_word want;
        if (owed_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d id %0d last %0d",
                                      i_kind, i_entry_id_res, i_last));
        end else begin
            want = owed_words.pop_front();
            if (i_kind !== want.kind || i_entry_id_res !== want.id || i_last !== want.last)
                report_mismatch($sformatf("got kind %0d id %0d last %0d, want %0d %0d %0d",
                                          i_kind, i_entry_id_res, i_last,
                                          want.kind, want.id, want.last));
        end
    endtask

    // Sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (psel && penable && pwrite && pready) write_cfg(paddr, pwdata);
            if (i_in_valid && !i_in_stall) take_word(i_operation, i_entry_id);
            if (i_out_valid && !i_out_stall) check_word();
        end
        o_words_owed <= owed_words.size();
    end

endmodule

[tb/ttl_aging_eviction_queue_tb.sv]
// Top of the TTL aging eviction queue testbench: clock, reset, stimulus and verdict.
// Depends on ttlq_pkg, the block ttl_aging_eviction_queue and ttlq_checker.
`timescale 1ns / 1ps

module ttl_aging_eviction_queue_tb;

    localparam int OP_W   = ttlq_pkg::OP_W;
    localparam int ID_W   = ttlq_pkg::ID_W;
    localparam int KIND_W = ttlq_pkg::KIND_W;
    localparam int CFG_W  = ttlq_pkg::CFG_W;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_operation    = '0;
    logic [ID_W-1:0]   i_entry_id     = '0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [KIND_W-1:0] o_kind;
    logic [ID_W-1:0]   o_entry_id_res;
    logic              o_last;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [3:0]        paddr          = '0;
    logic [31:0]       pwdata         = '0;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int words_owed;
    int cycle_cnt  = 0;
    int burst_left = 0;
    bit no_gaps    = 1'b0;
    int stall_mode = 0;
    int stall_run  = 0;
    int mode_left  = 0;

    ttl_aging_eviction_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_entry_id     (i_entry_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_entry_id_res (o_entry_id_res),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    ttlq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_entry_id     (i_entry_id),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_kind         (o_kind),
        .i_entry_id_res (o_entry_id_res),
        .i_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .o_fail_count   (fail_count),
        .o_words_owed   (words_owed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result channel in runs; the mode is redrawn when its random span runs out
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            mode_left  = $urandom_range(20, 150);
            stall_mode = $urandom_range(0, 3);
        end else begin
            mode_left--;
        end
        if (stall_run == 0) begin
            stall_run = $urandom_range(1, 8);
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ~i_out_stall;
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end else begin
            stall_run--;
        end
    end

    // Give up after the cycle limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("ttl_aging_eviction_queue_tb NOT OK");
        $finish;
    end

    // Offer one word; open a new burst with an optional gap when the last one ran out
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!no_gaps && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_entry_id  <= id;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    // Hold the sender until every owed word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (words_owed != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access phases, then an idle phase before the next transfer
    task automatic write_reg(input ttlq_pkg::t_reg idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic keep, input logic [CFG_W-1:0] min_f,
                              input logic [CFG_W-1:0] max_f, input logic [CFG_W-1:0] grow);
        write_reg(ttlq_pkg::REG_KEEP_RESIDENT, {{(CFG_W-1){1'b0}}, keep});
        write_reg(ttlq_pkg::REG_MIN_FRAMES, min_f);
        write_reg(ttlq_pkg::REG_MAX_FRAMES, max_f);
        write_reg(ttlq_pkg::REG_USAGE_GROWTH, grow);
    endtask

    // Mixed events and ticks on a small pool of ids, with occasional stray ids
    task automatic random_phase(input int n, input int id_hi);
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        int              r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 22)      op = ttlq_pkg::OP_LOAD;
            else if (r < 34) op = ttlq_pkg::OP_USED;
            else if (r < 44) op = ttlq_pkg::OP_SET_ACT;
            else if (r < 52) op = ttlq_pkg::OP_CLR_ACT;
            else if (r < 60) op = ttlq_pkg::OP_DESTROY;
            else if (r < 95) op = ttlq_pkg::OP_TICK;
            else             op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
            if ($urandom_range(0, 9) == 0 || op == ttlq_pkg::OP_TICK) id = ID_W'($urandom);
            else id = ID_W'($urandom_range(0, id_hi));
            send_word(op, id);
            if ($urandom_range(0, 59) == 0) drain();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, id extremes, duplicates, every operation
        send_word(ttlq_pkg::OP_LOAD, 6'd0);
        send_word(ttlq_pkg::OP_LOAD, 6'd63);
        send_word(ttlq_pkg::OP_LOAD, 6'd5);
        send_word(ttlq_pkg::OP_LOAD, 6'd5);
        send_word(ttlq_pkg::OP_USED, 6'd5);
        send_word(ttlq_pkg::OP_SET_ACT, 6'd63);
        send_word(ttlq_pkg::OP_TICK, 6'd0);
        send_word(ttlq_pkg::OP_DESTROY, 6'd5);
        send_word(ttlq_pkg::OP_TICK, 6'd0);
        send_word(ttlq_pkg::OP_TICK, 6'd63);
        send_word(ttlq_pkg::OP_CLR_ACT, 6'd63);
        send_word(OP_SPARE_LO, 6'd0);
        send_word(OP_SPARE_HI, 6'd63);
        send_word(ttlq_pkg::OP_USED, 6'd0);
        send_word(ttlq_pkg::OP_TICK, 6'd42);
        send_word(ttlq_pkg::OP_TICK, 6'd21);
        send_word(ttlq_pkg::OP_TICK, 6'd0);
        send_word(ttlq_pkg::OP_DESTROY, 6'd63);
        send_word(ttlq_pkg::OP_TICK, 6'd0);
        settle();

        // Zero lifetimes: entries expire almost at once
        set_config(1'b0, 16'd0, 16'd0, 16'd0);
        random_phase(45, 7);
        settle();

        // Fill past the depth without gaps, then age the full queue
        set_config(1'b0, 16'd2, 16'd9, 16'd3);
        no_gaps = 1'b1;
        for (int k = 0; k < 68; k++) send_word(ttlq_pkg::OP_LOAD, ID_W'($urandom));
        no_gaps = 1'b0;
        random_phase(40, 63);
        settle();

        // Resident mode: only dead entries leave
        write_reg(ttlq_pkg::REG_KEEP_RESIDENT, 16'd1);
        random_phase(35, 15);
        settle();

        // Largest lifetimes and growth
        set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(35, 7);
        settle();

        // Short cap with large growth, first without input gaps, then with gaps
        set_config(1'b0, 16'd1, 16'd5, 16'hFFFF);
        no_gaps = 1'b1;
        random_phase(25, 7);
        no_gaps = 1'b0;
        random_phase(25, 7);
        settle();

        if (fail_count == 0 && words_owed == 0) begin
            $display("ttl_aging_eviction_queue_tb OK");
        end else begin
            $display("ttl_aging_eviction_queue_tb NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ttlq_pkg.sv
rtl/ttlq_cfg.sv
rtl/ttlq_ctrl.sv
rtl/ttlq_dpath.sv
rtl/ttl_aging_eviction_queue.sv
tb/ttlq_checker.sv
tb/ttl_aging_eviction_queue_tb.sv
